### rtl/alt_pkg.sv
// Shared types, constants and helper functions for the assembly line tokenizer.
package alt_pkg;

   // Longest token kept; later characters of the token are dropped.
   localparam int MAX_WORD = 64;
   localparam int CNT_W    = $clog2(MAX_WORD + 1);

   // Result kinds.
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_LINE = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SEMI  = 8'd59;
   localparam logic [7:0] CH_BSL   = 8'h5C;

   // One result record.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_value;
      logic       is_string;
      logic [7:0] token_index;
      logic [5:0] char_index;
      logic       truncated;
   } rec_type;

   // All results caused by one input character (one or two records).
   typedef struct packed {
      logic    two;
      rec_type r0;
      rec_type r1;
   } job_type;

   // Queue status seen by the back end.
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // Escape decoding; an unknown escape passes the character through.
   function automatic logic [7:0] decode_escape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h61:   r = 8'h07;  // a
         8'h62:   r = 8'h08;  // b
         8'h66:   r = 8'h0C;  // f
         8'h6E:   r = 8'h0A;  // n
         8'h72:   r = 8'h0D;  // r
         8'h74:   r = 8'h09;  // t
         8'h76:   r = 8'h0B;  // v
         default: r = c;      // quote, apostrophe, ?, backslash and others
      endcase
      return r;
   endfunction

   function automatic logic is_line_end(input logic [7:0] c);
      return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR) || (c == CH_SEMI);
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);
   endfunction

endpackage

### rtl/alt_front.sv
// Front end: scans one character per cycle while accept is high, keeps the line state and builds result jobs.
module alt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       char_in,
   output logic             job_valid,
   output alt_pkg::job_type job
);

   localparam logic [2:0] MODE_GAP    = 3'd0;
   localparam logic [2:0] MODE_WORD   = 3'd1;
   localparam logic [2:0] MODE_STR    = 3'd2;
   localparam logic [2:0] MODE_ESC    = 3'd3;
   localparam logic [2:0] MODE_AFTER  = 3'd4;
   localparam logic [2:0] MODE_IGNORE = 3'd5;

   logic [2:0]              mode_ff, mode_in;
   logic [7:0]              tok_ff, tok_in;
   logic [alt_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                    ovf_ff, ovf_in;

   logic [7:0]              tok_inc;
   logic                    room;
   logic [1:0]              nres;

   assign tok_inc = (tok_ff == 8'hFF) ? tok_ff : tok_ff + 8'd1;
   assign room    = cnt_ff < alt_pkg::CNT_W'(alt_pkg::MAX_WORD);

   // Next-state and result decode for the current character.
   always_comb begin
      mode_in = mode_ff;
      tok_in  = tok_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      nres    = 2'd0;
      job     = '0;
      case (mode_ff)
         MODE_GAP, MODE_AFTER: begin
            if (alt_pkg::is_line_end(char_in)) begin
               nres                 = 2'd1;
               job.r0.kind          = alt_pkg::KIND_LINE;
               job.r0.token_index   = tok_ff;
               if (char_in == alt_pkg::CH_NUL) begin
                  mode_in = MODE_GAP;
                  tok_in  = '0;
                  cnt_in  = '0;
                  ovf_in  = 1'b0;
               end else begin
                  mode_in = MODE_IGNORE;
               end
            end else if (alt_pkg::is_delim(char_in)) begin
               mode_in = MODE_GAP;
            end else if (char_in == alt_pkg::CH_QUOTE) begin
               cnt_in  = '0;
               ovf_in  = 1'b0;
               mode_in = MODE_STR;
            end else if (mode_ff == MODE_GAP) begin
               // First character of a word always fits.
               nres               = 2'd1;
               job.r0.kind        = alt_pkg::KIND_CHAR;
               job.r0.char_value  = char_in;
               job.r0.token_index = tok_ff;
               cnt_in             = alt_pkg::CNT_W'(1);
               ovf_in             = 1'b0;
               mode_in            = MODE_WORD;
            end
         end
         MODE_WORD: begin
            if (alt_pkg::is_line_end(char_in) || alt_pkg::is_delim(char_in)) begin
               nres               = 2'd1;
               job.r0.kind        = alt_pkg::KIND_END;
               job.r0.token_index = tok_ff;
               job.r0.truncated   = ovf_ff;
               tok_in             = tok_inc;
               cnt_in             = '0;
               ovf_in             = 1'b0;
               mode_in            = MODE_GAP;
               if (alt_pkg::is_line_end(char_in)) begin
                  nres               = 2'd2;
                  job.two            = 1'b1;
                  job.r1.kind        = alt_pkg::KIND_LINE;
                  job.r1.token_index = tok_inc;
                  if (char_in == alt_pkg::CH_NUL) begin
                     tok_in = '0;
                  end else begin
                     mode_in = MODE_IGNORE;
                  end
               end
            end else if (room) begin
               nres               = 2'd1;
               job.r0.kind        = alt_pkg::KIND_CHAR;
               job.r0.char_value  = char_in;
               job.r0.token_index = tok_ff;
               job.r0.char_index  = 6'(cnt_ff);
               cnt_in             = alt_pkg::CNT_W'(cnt_ff + 1'b1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         MODE_STR, MODE_ESC: begin
            if (char_in == alt_pkg::CH_NUL) begin
               // Open string or pending escape at end of line.
               nres               = 2'd2;
               job.two            = 1'b1;
               job.r0.kind        = alt_pkg::KIND_END;
               job.r0.is_string   = 1'b1;
               job.r0.token_index = tok_ff;
               job.r0.truncated   = ovf_ff;
               job.r1.kind        = alt_pkg::KIND_LINE;
               job.r1.token_index = tok_inc;
               mode_in            = MODE_GAP;
               tok_in             = '0;
               cnt_in             = '0;
               ovf_in             = 1'b0;
            end else if (mode_ff == MODE_STR && char_in == alt_pkg::CH_QUOTE) begin
               nres               = 2'd1;
               job.r0.kind        = alt_pkg::KIND_END;
               job.r0.is_string   = 1'b1;
               job.r0.token_index = tok_ff;
               job.r0.truncated   = ovf_ff;
               tok_in             = tok_inc;
               cnt_in             = '0;
               ovf_in             = 1'b0;
               mode_in            = MODE_AFTER;
            end else if (mode_ff == MODE_STR && char_in == alt_pkg::CH_BSL) begin
               mode_in = MODE_ESC;
            end else begin
               mode_in = MODE_STR;
               if (room) begin
                  nres               = 2'd1;
                  job.r0.kind        = alt_pkg::KIND_CHAR;
                  job.r0.char_value  = (mode_ff == MODE_ESC) ?
                                       alt_pkg::decode_escape(char_in) : char_in;
                  job.r0.is_string   = 1'b1;
                  job.r0.token_index = tok_ff;
                  job.r0.char_index  = 6'(cnt_ff);
                  cnt_in             = alt_pkg::CNT_W'(cnt_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         default: begin
            // Rest of the line is skipped until NUL.
            if (char_in == alt_pkg::CH_NUL) begin
               mode_in = MODE_GAP;
               tok_in  = '0;
               cnt_in  = '0;
               ovf_in  = 1'b0;
            end else begin
               mode_in = MODE_IGNORE;
            end
         end
      endcase
   end

   assign job_valid = accept && (nres != 2'd0);

   // Line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GAP;
         tok_ff  <= '0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         tok_ff  <= tok_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

### rtl/alt_queue.sv
// Four-entry job queue between the front end and the back end.
module alt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  alt_pkg::job_type   push_job,
   input  logic               pop,
   output alt_pkg::job_type   head,
   output alt_pkg::qstat_type stat
);

   alt_pkg::job_type slot_ff [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] fill_ff, fill_in;

   assign head       = slot_ff[rd_ff];
   assign stat.empty = (fill_ff == 3'd0);
   assign stat.full  = (fill_ff == 3'd4);

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_in   = push ? wr_ff + 2'd1 : wr_ff;
      rd_in   = pop ? rd_ff + 2'd1 : rd_ff;
      fill_in = fill_ff + {2'b00, push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

### rtl/alt_back.sv
// Back end: expands queued jobs into single results held in the output register.
module alt_back (
   input  logic               clock,
   input  logic               reset,
   input  alt_pkg::job_type   head,
   input  alt_pkg::qstat_type stat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_char_value,
   output logic               rsp_is_string,
   output logic [7:0]         rsp_token_index,
   output logic [5:0]         rsp_char_index,
   output logic               rsp_truncated,
   output logic               rsp_last_of_run
);

   logic             valid_ff, valid_in;
   logic             second_ff, second_in;
   alt_pkg::rec_type rec_ff, rec_in;
   logic             last_ff, last_in;
   logic             load;

   // The output register takes a new result when it is empty or being taken.
   assign load = (!valid_ff || !rsp_stall) && !stat.empty;

   always_comb begin
      valid_in  = valid_ff && rsp_stall;
      second_in = second_ff;
      rec_in    = rec_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (second_ff) begin
            rec_in    = head.r1;
            last_in   = 1'b1;
            second_in = 1'b0;
            pop       = 1'b1;
         end else begin
            rec_in    = head.r0;
            last_in   = !head.two;
            second_in = head.two;
            pop       = !head.two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = rec_ff.kind;
   assign rsp_char_value  = rec_ff.char_value;
   assign rsp_is_string   = rec_ff.is_string;
   assign rsp_token_index = rec_ff.token_index;
   assign rsp_char_index  = rec_ff.char_index;
   assign rsp_truncated   = rec_ff.truncated;
   assign rsp_last_of_run = last_ff;

endmodule

### rtl/assembly_line_tokenizer.sv
// Top level of the assembly line tokenizer: front end, job queue and back end.
//
//   Channel | Direction | Ports
//   req     | in        | req_valid, req_stall, req_char_in
//   rsp     | out       | rsp_valid, rsp_stall, rsp_kind .. rsp_last_of_run
//
// One character is scanned per cycle while req_stall is low; a character that
// yields one result moves through at one per cycle while rsp_stall is low, one
// that yields two results holds the back end until both are taken.
// Reset is synchronous and returns the line state to the gap after a delimiter.
// req_stall rises only when the four-entry job queue is full.
module assembly_line_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_char_value,
   output logic       rsp_is_string,
   output logic [7:0] rsp_token_index,
   output logic [5:0] rsp_char_index,
   output logic       rsp_truncated,
   output logic       rsp_last_of_run
);

   alt_pkg::job_type   job;
   alt_pkg::job_type   head;
   alt_pkg::qstat_type stat;
   logic               accept;
   logic               job_valid;
   logic               pop;

   assign req_stall = stat.full;
   assign accept    = req_valid && !stat.full;

   alt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_in   (req_char_in),
      .job_valid (job_valid),
      .job       (job)
   );

   alt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .stat     (stat)
   );

   alt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .stat            (stat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_char_value  (rsp_char_value),
      .rsp_is_string   (rsp_is_string),
      .rsp_token_index (rsp_token_index),
      .rsp_char_index  (rsp_char_index),
      .rsp_truncated   (rsp_truncated),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### rtl/alt_checker.sv
// Port-level checks for the assembly line tokenizer and their bind.
module alt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_char_in,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_char_value,
   input logic       rsp_is_string,
   input logic [7:0] rsp_token_index,
   input logic [5:0] rsp_char_index,
   input logic       rsp_truncated,
   input logic       rsp_last_of_run
);

   // A stalled result transaction holds its kind, character, token index and character index.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_char_value) && $stable(rsp_token_index) && $stable(rsp_char_index))
      else $error("stalled result changed");

   // A token end that is not last is followed at once by the line end.
   a_end_then_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == alt_pkg::KIND_END && !rsp_last_of_run
      |=> rsp_valid && rsp_kind == alt_pkg::KIND_LINE)
      else $error("token end not followed by line end");

   // A line end closes the run of results and carries no string flag, truncation or character.
   a_line_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == alt_pkg::KIND_LINE
      |-> rsp_last_of_run && !rsp_is_string && !rsp_truncated && rsp_char_value == 8'h00)
      else $error("malformed line end");

   // Only token characters carry a character and a position.
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != alt_pkg::KIND_CHAR
      |-> rsp_char_value == 8'h00 && rsp_char_index == 6'd0)
      else $error("marker carries character data");

endmodule

bind assembly_line_tokenizer alt_checker u_alt_checker (.*);
